### rtl/fwsc_pkg.sv
// fwsc_pkg: shared types, codes and constants for the friction wheel spin-up controller
// used by fwsc_ctrl, fwsc_dp and friction_wheel_spinup_controller_top; no dependencies
`timescale 1ns / 1ps

package fwsc_pkg;

  localparam int DUTY_W   = 16;
  localparam int TICKS_W  = 16;
  localparam int STOP_W   = 15;
  localparam int HOLD_W   = 16;  // width of the right-button hold counter
  localparam int CMP_W    = (HOLD_W > STOP_W) ? HOLD_W : STOP_W;
  localparam int PROD_W   = DUTY_W + TICKS_W;
  localparam int DIV_STEPS = TICKS_W;
  localparam int STEP_W   = $clog2(DIV_STEPS);
  localparam int CFG_IDX_W = 2;

  localparam logic [DUTY_W-1:0]  MAX_DUTY_RST   = DUTY_W'(1500);
  localparam logic [DUTY_W-1:0]  IDLE_DUTY_RST  = DUTY_W'(1000);
  localparam logic [TICKS_W-1:0] RAMP_TICKS_RST = TICKS_W'(100);
  localparam logic [STOP_W-1:0]  STOP_HOLD_RST  = STOP_W'(50);
  localparam logic [HOLD_W-1:0]  HOLD_MAX       = {HOLD_W{1'b1}};

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DUTY   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IDLE_DUTY  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RAMP_TICKS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_HOLD  = 2'd3;

  // tick sources, switch events and switch positions
  localparam logic       KIND_REMOTE = 1'b0;
  localparam logic [1:0] EVT_ON      = 2'd1;
  localparam logic [1:0] EVT_OFF     = 2'd2;
  localparam logic [1:0] POS_SHOOT   = 2'd2;

  typedef enum logic [1:0] {
    WHEEL_OFF    = 2'd0,
    WHEEL_SPINUP = 2'd1,
    WHEEL_ON     = 2'd2
  } wheel_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_MUL,
    ST_DIV,
    ST_DONE
  } ctrl_state_t;

  typedef struct packed {
    logic capture;
    logic eval;
    logic mul;
    logic div_step;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic need_div;
  } dp_status_t;

endpackage

### rtl/friction_wheel_spinup_controller_top.sv
// Friction wheel spin-up controller: takes one control tick item (remote switch or mouse)
// and returns one item with the PWM compare value, wheel mode and shoot flag. A tick is
// captured, evaluated and then loaded into the output register; a tick that steps the
// spin-up ramp also passes through the 16x16 multiply and the restoring divider, which
// produces one quotient bit per cycle, before that load. The input is stalled
// from acceptance until the result is loaded into the output register; the next item
// can then be taken while that result still waits downstream.
// depends on fwsc_pkg, fwsc_ctrl and fwsc_dp
`timescale 1ns / 1ps

module friction_wheel_spinup_controller_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [fwsc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fwsc_pkg::DUTY_W-1:0]    cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           kind,
  input  logic [1:0]                     switch_event,
  input  logic [1:0]                     switch_position,
  input  logic                           right_button,
  input  logic                           left_button,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [fwsc_pkg::DUTY_W-1:0]    duty,
  output logic                           duty_updated,
  output logic [1:0]                     wheel_mode,
  output logic                           shooting
);
  import fwsc_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  fwsc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .status    (status)
  );

  fwsc_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .kind            (kind),
    .switch_event    (switch_event),
    .switch_position (switch_position),
    .right_button    (right_button),
    .left_button     (left_button),
    .cmd             (cmd),
    .status          (status),
    .duty            (duty),
    .duty_updated    (duty_updated),
    .wheel_mode      (wheel_mode),
    .shooting        (shooting)
  );

`ifndef SYNTHESIS
  // an accepted item keeps the input closed on the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input open right after an accepted item");

  // a new result only appears while an item is in flight
  a_result_from_item: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared with no item in flight");

  // a ramp step goes from evaluation straight to the multiply
  a_eval_to_mul: assert property (@(posedge clk) disable iff (rst)
    (cmd.eval && status.need_div) |=> cmd.mul)
    else $error("ramp step did not move on to the multiply");

  a_reset_clears_out: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");
`endif

endmodule

### rtl/fwsc_ctrl.sv
// fwsc_ctrl: sequencer for one tick item (capture, evaluate, multiply, divide, deliver)
// depends on fwsc_pkg; drives the datapath commands and both handshakes
`timescale 1ns / 1ps

module fwsc_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  output fwsc_pkg::dp_cmd_t   cmd,
  input  fwsc_pkg::dp_status_t status
);
  import fwsc_pkg::*;

  ctrl_state_t        state, state_next;
  logic [STEP_W-1:0]  step, step_next;
  logic               out_free;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      step  <= step_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    step_next  = step;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_EVAL;
        end
      end
      ST_EVAL: begin
        cmd.eval   = 1'b1;
        state_next = status.need_div ? ST_MUL : ST_DONE;
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        step_next  = '0;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        step_next    = step + 1'b1;
        if (step == STEP_W'(DIV_STEPS - 1)) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

### rtl/fwsc_dp.sv
// fwsc_dp: wheel state, config registers, ramp multiplier and restoring divider
// depends on fwsc_pkg; steered by fwsc_ctrl through dp_cmd_t
`timescale 1ns / 1ps

module fwsc_dp (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [fwsc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fwsc_pkg::DUTY_W-1:0]  cfg_data,
  input  logic                         kind,
  input  logic [1:0]                   switch_event,
  input  logic [1:0]                   switch_position,
  input  logic                         right_button,
  input  logic                         left_button,
  input  fwsc_pkg::dp_cmd_t            cmd,
  output fwsc_pkg::dp_status_t         status,
  output logic [fwsc_pkg::DUTY_W-1:0]  duty,
  output logic                         duty_updated,
  output logic [1:0]                   wheel_mode,
  output logic                         shooting
);
  import fwsc_pkg::*;

  // configuration
  logic [DUTY_W-1:0]  max_duty, idle_duty;
  logic [TICKS_W-1:0] ramp_ticks;
  logic [STOP_W-1:0]  stop_hold_ticks;

  // tick state
  wheel_t             wheel, wheel_next;
  logic [TICKS_W-1:0] ramp_count, ramp_count_next;
  logic [HOLD_W-1:0]  hold_count, hold_count_next;
  logic               prev_right, prev_right_next;
  logic               prev_left, prev_left_next;
  logic               shoot_flag, shoot_flag_next;
  logic [DUTY_W-1:0]  duty_reg;
  logic               updated, updated_next;
  logic               ramp_pend;

  // captured item
  logic               in_kind;
  logic [1:0]         in_evt, in_pos;
  logic               in_rb, in_lb;

  // ramp arithmetic
  logic [TICKS_W-1:0] rem;
  logic [DUTY_W-1:0]  dq;
  logic               down;
  logic [DUTY_W-1:0]  diff;
  logic [PROD_W-1:0]  prod;
  logic [TICKS_W:0]   trial, trial_sub;
  logic               trial_ge;
  logic [DUTY_W-1:0]  ramp_val, duty_final;

  logic               do_stop, do_ramp, idle_wr, div_next;
  logic [TICKS_W:0]   cnt_inc;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_duty        <= MAX_DUTY_RST;
      idle_duty       <= IDLE_DUTY_RST;
      ramp_ticks      <= RAMP_TICKS_RST;
      stop_hold_ticks <= STOP_HOLD_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MAX_DUTY:   max_duty        <= cfg_data;
        REG_IDLE_DUTY:  idle_duty       <= cfg_data;
        REG_RAMP_TICKS: ramp_ticks      <= cfg_data;
        REG_STOP_HOLD:  stop_hold_ticks <= cfg_data[STOP_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      in_kind <= kind;
      in_evt  <= switch_event;
      in_pos  <= switch_position;
      in_rb   <= right_button;
      in_lb   <= left_button;
    end
  end

  // tick evaluation
  assign cnt_inc = {1'b0, ramp_count} + 1'b1;

  always_comb begin
    wheel_next      = wheel;
    ramp_count_next = ramp_count;
    hold_count_next = hold_count;
    prev_right_next = prev_right;
    prev_left_next  = prev_left;
    shoot_flag_next = shoot_flag;
    updated_next    = 1'b0;
    do_stop         = 1'b0;
    do_ramp         = 1'b0;
    idle_wr         = 1'b0;
    div_next        = 1'b0;
    if (in_kind == KIND_REMOTE) begin
      unique case (wheel)
        WHEEL_SPINUP: begin
          if (in_evt == EVT_OFF) begin
            do_stop = 1'b1;
          end else begin
            do_ramp = 1'b1;
          end
          updated_next = 1'b1;
        end
        WHEEL_ON: begin
          if (in_evt == EVT_OFF) begin
            do_stop      = 1'b1;
            updated_next = 1'b1;
          end else begin
            shoot_flag_next = (in_pos == POS_SHOOT);
          end
        end
        default: begin
          if (in_evt == EVT_ON) begin
            shoot_flag_next = 1'b0;
            ramp_count_next = '0;
            wheel_next      = WHEEL_SPINUP;
          end
        end
      endcase
    end else begin
      if (wheel == WHEEL_SPINUP || wheel == WHEEL_ON) begin
        if (in_rb) begin
          hold_count_next = (hold_count == HOLD_MAX) ? hold_count : hold_count + 1'b1;
        end else begin
          hold_count_next = '0;
        end
        if (CMP_W'(hold_count_next) > CMP_W'(stop_hold_ticks)) begin
          do_stop      = 1'b1;
          updated_next = 1'b1;
        end else if (wheel == WHEEL_SPINUP) begin
          do_ramp      = 1'b1;
          updated_next = 1'b1;
        end else if (!prev_left) begin
          // a fresh press sets the flag, no press clears it
          shoot_flag_next = in_lb;
        end
      end else if (!prev_right && in_rb) begin
        shoot_flag_next = 1'b0;
        ramp_count_next = '0;
        wheel_next      = WHEEL_SPINUP;
        hold_count_next = '0;
      end
      prev_right_next = in_rb;
      prev_left_next  = in_lb;
    end

    if (do_stop) begin
      wheel_next      = WHEEL_OFF;
      idle_wr         = 1'b1;
      ramp_count_next = '0;
      shoot_flag_next = 1'b0;
    end

    if (do_ramp) begin
      if (ramp_ticks == '0) begin
        idle_wr    = 1'b1;
        wheel_next = WHEEL_ON;
      end else begin
        div_next = 1'b1;
        if (cnt_inc >= {1'b0, ramp_ticks}) begin
          ramp_count_next = ramp_ticks;
          wheel_next      = WHEEL_ON;
        end else begin
          ramp_count_next = cnt_inc[TICKS_W-1:0];
        end
      end
    end
  end

  assign status.need_div = div_next;

  // ramp term: |max - idle| * count / ticks
  assign down = (max_duty < idle_duty);
  assign diff = down ? (idle_duty - max_duty) : (max_duty - idle_duty);
  assign prod = PROD_W'(diff) * PROD_W'(ramp_count);

  // count <= ticks keeps the upper product half below ticks, so 16 steps suffice
  assign trial     = {rem, dq[DUTY_W-1]};
  assign trial_ge  = (trial >= {1'b0, ramp_ticks});
  assign trial_sub = trial - {1'b0, ramp_ticks};

  assign ramp_val   = down ? (idle_duty - dq) : (idle_duty + dq);
  assign duty_final = ramp_pend ? ramp_val : duty_reg;

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      rem <= prod[PROD_W-1:DUTY_W];
      dq  <= prod[DUTY_W-1:0];
    end else if (cmd.div_step) begin
      rem <= trial_ge ? trial_sub[TICKS_W-1:0] : trial[TICKS_W-1:0];
      dq  <= {dq[DUTY_W-2:0], trial_ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wheel      <= WHEEL_OFF;
      ramp_count <= '0;
      hold_count <= '0;
      prev_right <= 1'b0;
      prev_left  <= 1'b0;
      shoot_flag <= 1'b0;
      duty_reg   <= IDLE_DUTY_RST;
      updated    <= 1'b0;
      ramp_pend  <= 1'b0;
    end else begin
      if (cmd.eval) begin
        wheel      <= wheel_next;
        ramp_count <= ramp_count_next;
        hold_count <= hold_count_next;
        prev_right <= prev_right_next;
        prev_left  <= prev_left_next;
        shoot_flag <= shoot_flag_next;
        updated    <= updated_next;
        ramp_pend  <= div_next;
        if (idle_wr) begin
          duty_reg <= idle_duty;
        end
      end else if (cmd.load_out) begin
        duty_reg  <= duty_final;
        ramp_pend <= 1'b0;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      duty         <= duty_final;
      duty_updated <= updated;
      wheel_mode   <= (wheel == WHEEL_SPINUP || wheel == WHEEL_ON) ? wheel : WHEEL_OFF;
      shooting     <= shoot_flag;
    end
  end

endmodule
